/* hdl/cbm_pkg.sv */
// Package for the cartridge bank mapper: access and result word types,
// target codes, register indexes and the RAM size decode.
// No dependencies.
`default_nettype none

package cbm_pkg;

   // Cap on the number of RAM banks that banks_present reports.
   localparam int unsigned MAX_RAM_BANKS = 16;
   localparam int unsigned BANK_COUNT_W  = 5;

   // Configuration port geometry and register indexes.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_BANKING_ENABLED = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAM_SIZE_CODE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BATTERY_BACKED  = 2'd2;

   // Bus address regions, decoded on address bits 15:13.
   localparam logic [2:0] REGION_RAM_ENABLE = 3'b000;
   localparam logic [2:0] REGION_ROM_BANK   = 3'b001;
   localparam logic [2:0] REGION_RAM_BANK   = 3'b010;
   localparam logic [2:0] REGION_MODE       = 3'b011;
   localparam logic [2:0] REGION_RAM_WINDOW = 3'b101;

   // Low nibble that switches external RAM on.
   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

   // Access kinds.
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Header RAM size codes.
   localparam logic [2:0] RAM_CODE_ONE     = 3'd2;
   localparam logic [2:0] RAM_CODE_FOUR    = 3'd3;
   localparam logic [2:0] RAM_CODE_SIXTEEN = 3'd4;
   localparam logic [2:0] RAM_CODE_EIGHT   = 3'd5;

   typedef enum logic [2:0] {
      TGT_NONE   = 3'd0,
      TGT_ROM    = 3'd1,
      TGT_RAM_RD = 3'd2,
      TGT_RAM_WR = 3'd3,
      TGT_REG    = 3'd4
   } target_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] address;
      logic [7:0]  data_in;
   } req_word_type;

   typedef struct packed {
      target_type  target;
      logic [18:0] mem_address;
      logic [7:0]  write_data;
      logic        save_request;
      logic        dirty;
   } rsp_word_type;

   // Banks present for a header RAM size code, capped at MAX_RAM_BANKS.
   function automatic logic [BANK_COUNT_W-1:0] banks_present(input logic [2:0] code);
      logic [BANK_COUNT_W-1:0] n;
      case (code)
         RAM_CODE_ONE:     n = 5'd1;
         RAM_CODE_FOUR:    n = 5'd4;
         RAM_CODE_SIXTEEN: n = 5'd16;
         RAM_CODE_EIGHT:   n = 5'd8;
         default:          n = 5'd0;
      endcase
      if (n > BANK_COUNT_W'(MAX_RAM_BANKS)) begin
         n = BANK_COUNT_W'(MAX_RAM_BANKS);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

/* hdl/cartridge_bank_mapper.sv */
// Cartridge bank mapper top level: decodes bus accesses into ROM, RAM or
// bank register operations. Depends on cbm_pkg.
`default_nettype none

//  Channel   Ports                            Direction  Moves
//  req       req_valid/req_ready/req_word      in         one bus access word
//  rsp       rsp_valid/rsp_ready/rsp_word      out        one translated word
//  csr       csr_write_en/csr_index/csr_wdata  in         register write, no wait
//
// One word is accepted per cycle while req_ready is high. Its result moves
// through the input register, the single decode stage and the result register,
// which drives rsp_valid and rsp_word. Reset is synchronous and returns valid
// flags, bank state and configuration to their reset values. While a result
// waits, the input register still takes one word; after that req_ready stays
// low until the result is taken.

module cartridge_bank_mapper
   import cbm_pkg::*;
#(
   parameter int unsigned ROM_BANK_BITS = 5
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_word_type           req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_word_type                rsp_word,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned ROM_ADDR_W = ROM_BANK_BITS + 14;

   // Configuration registers.
   logic       banking_enabled_ff;
   logic [2:0] ram_size_code_ff;
   logic       battery_backed_ff;

   // Bank state.
   logic                     ram_enable_ff, ram_enable_in;
   logic [ROM_BANK_BITS-1:0] rom_bank_ff, rom_bank_in;
   logic [2:0]               ram_bank_select_ff, ram_bank_select_in;
   logic [2:0]               active_ram_bank_ff, active_ram_bank_in;
   logic                     banking_mode_ff, banking_mode_in;
   logic                     unsaved_ff, unsaved_in;

   // Pipeline registers.
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         out_valid_ff;
   rsp_word_type out_word_ff, out_word_in;

   logic                  advance;
   logic [2:0]            region;
   logic                  ram_usable;
   logic [ROM_ADDR_W-1:0] rom_full;
   logic [15:0]           ram_full;
   logic [7:0]            bank_value;
   logic                  switch_bank;

   // Handshake: the input register frees whenever its word moves on.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   // Address composition.
   assign region     = in_word_ff.address[15:13];
   assign ram_usable = ram_enable_ff &&
                       ({2'b00, active_ram_bank_ff} < banks_present(ram_size_code_ff));
   assign rom_full   = {rom_bank_ff, in_word_ff.address[13:0]};
   assign ram_full   = {active_ram_bank_ff, in_word_ff.address[12:0]};
   assign bank_value = (in_word_ff.data_in == 8'd0) ? 8'd1 : in_word_ff.data_in;

   // Decode of the word in the input register and the next bank state.
   always_comb begin
      ram_enable_in      = ram_enable_ff;
      rom_bank_in        = rom_bank_ff;
      ram_bank_select_in = ram_bank_select_ff;
      active_ram_bank_in = active_ram_bank_ff;
      banking_mode_in    = banking_mode_ff;
      unsaved_in         = unsaved_ff;
      switch_bank        = 1'b0;

      out_word_in              = '0;
      out_word_in.target       = TGT_NONE;

      if (in_word_ff.kind == KIND_READ) begin
         case (region)
            REGION_RAM_ENABLE, REGION_ROM_BANK: begin
               out_word_in.target      = TGT_ROM;
               out_word_in.mem_address = {3'b000, in_word_ff.address};
            end
            REGION_RAM_BANK, REGION_MODE: begin
               out_word_in.target = TGT_ROM;
               if (banking_enabled_ff) begin
                  out_word_in.mem_address = 19'(rom_full);
               end else begin
                  out_word_in.mem_address = {3'b000, in_word_ff.address};
               end
            end
            REGION_RAM_WINDOW: begin
               if (ram_usable) begin
                  out_word_in.target      = TGT_RAM_RD;
                  out_word_in.mem_address = {3'b000, ram_full};
               end
            end
            default: begin
               out_word_in.target = TGT_NONE;
            end
         endcase
      end else begin
         case (region)
            REGION_RAM_ENABLE: begin
               out_word_in.target = TGT_REG;
               ram_enable_in      = (in_word_ff.data_in[3:0] == RAM_ENABLE_KEY);
            end
            REGION_ROM_BANK: begin
               out_word_in.target = TGT_REG;
               rom_bank_in        = ROM_BANK_BITS'(bank_value);
            end
            REGION_RAM_BANK: begin
               out_word_in.target = TGT_REG;
               ram_bank_select_in = in_word_ff.data_in[2:0];
               switch_bank        = 1'b1;
            end
            REGION_MODE: begin
               out_word_in.target = TGT_REG;
               banking_mode_in    = in_word_ff.data_in[0];
               switch_bank        = 1'b1;
            end
            REGION_RAM_WINDOW: begin
               if (ram_usable) begin
                  out_word_in.target      = TGT_RAM_WR;
                  out_word_in.mem_address = {3'b000, ram_full};
                  out_word_in.write_data  = in_word_ff.data_in;
                  if (battery_backed_ff) begin
                     unsaved_in = 1'b1;
                  end
               end
            end
            default: begin
               out_word_in.target = TGT_NONE;
            end
         endcase
      end

      // A bank switch in mode 0 takes over the selected bank and asks for a
      // save when battery RAM holds unsaved writes.
      if (switch_bank && !banking_mode_in) begin
         active_ram_bank_in = ram_bank_select_in;
         if (unsaved_ff && battery_backed_ff) begin
            out_word_in.save_request = 1'b1;
            unsaved_in               = 1'b0;
         end
      end

      out_word_in.dirty = unsaved_in;
   end

   // Control, configuration and bank state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         banking_enabled_ff <= 1'b1;
         ram_size_code_ff   <= 3'd0;
         battery_backed_ff  <= 1'b0;
         ram_enable_ff      <= 1'b0;
         rom_bank_ff        <= ROM_BANK_BITS'(1);
         ram_bank_select_ff <= 3'd0;
         active_ram_bank_ff <= 3'd0;
         banking_mode_ff    <= 1'b0;
         unsaved_ff         <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff       <= 1'b1;
            ram_enable_ff      <= ram_enable_in;
            rom_bank_ff        <= rom_bank_in;
            ram_bank_select_ff <= ram_bank_select_in;
            active_ram_bank_ff <= active_ram_bank_in;
            banking_mode_ff    <= banking_mode_in;
            unsaved_ff         <= unsaved_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_BANKING_ENABLED: banking_enabled_ff <= csr_wdata[0];
               CSR_RAM_SIZE_CODE:   ram_size_code_ff   <= csr_wdata;
               CSR_BATTERY_BACKED:  battery_backed_ff  <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

endmodule

`default_nettype wire
